// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/rhpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rhpm_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int INDEX_BITS_DEF  = 32;

  localparam int HASH_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int STEP_W  = $clog2(BYTE_W);
  localparam int CMD_W   = 2;
  localparam int OUT_IDX_W = 32;

  localparam logic [HASH_W-1:0] MODULUS_RESET = 16'd101;

  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  typedef struct packed {
    logic              abort;
    logic              start;
    logic              mul;
    logic [HASH_W-1:0] init;
    logic [BYTE_W-1:0] data;
    logic [HASH_W-1:0] mcand;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

`default_nettype wire

// ----- rtl/rhpm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rhpm_in_if import rhpm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/rhpm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface rhpm_out_if import rhpm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 true_match;
  logic [OUT_IDX_W-1:0] start_index;

  modport source (output valid, output true_match, output start_index, input ready);
  modport sink (input valid, input true_match, input start_index, output ready);
endinterface

`default_nettype wire

// ----- rtl/rhpm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rhpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/rhpm_mod_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Computes (2*r + a) mod m once per cycle over the eight bits of a byte, MSB
// first. In shift mode a is the bit, giving (init*256 + data) mod m. In
// multiply mode a is the bit times mcand, giving (data*mcand) mod m.
module rhpm_mod_unit import rhpm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mod_req_t          req,
  input  wire logic [HASH_W-1:0] m,
  output mod_stat_t              stat,
  output logic      [HASH_W-1:0] res
);

  logic              active;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [HASH_W-1:0] r;
  logic [BYTE_W-1:0] sh;
  logic              mul;
  logic [HASH_W-1:0] mcand;

  logic              bitv;
  logic [HASH_W-1:0] addend;
  logic [HASH_W+1:0] t;
  logic [HASH_W+1:0] m1;
  logic [HASH_W+1:0] m2;
  logic [HASH_W+1:0] tr;

  always_comb begin
    bitv   = sh[BYTE_W-1];
    addend = mul ? (bitv ? mcand : '0) : HASH_W'(bitv);
    t      = {1'b0, r, 1'b0} + {2'b00, addend};
    m1     = {2'b00, m};
    m2     = {1'b0, m, 1'b0};
    if (t >= m2) begin
      tr = t - m2;
    end else if (t >= m1) begin
      tr = t - m1;
    end else begin
      tr = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.abort) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt    <= '0;
        r      <= req.init;
        sh     <= req.data;
        mul    <= req.mul;
        mcand  <= req.mcand;
      end else if (active) begin
        r   <= tr[HASH_W-1:0];
        sh  <= {sh[BYTE_W-2:0], 1'b0};
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(BYTE_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = active;
  assign stat.done = done;
  assign res       = r;

  `ASSERT_IMPLIES(a_no_restart, clk, rst, req.start && !req.abort, !active)

endmodule

`default_nettype wire

// ----- rtl/rolling_hash_pattern_matcher_core.sv -----
// Rabin-Karp matcher over a byte stream.
// Requests arrive on the item channel (valid/ready) with a command and a byte:
// text byte, append pattern byte, or clear pattern and text. Results leave on
// the result channel (valid/ready): the start index of a window whose hash
// equals the pattern hash, and whether the bytes really match.
// The modulus register is written through cfg_we/cfg_wdata; a write also
// clears the pattern and the text.
// One request is worked at a time on a shared modular step unit that handles
// one bit per cycle. A pattern byte runs a hash step, then a power step. A
// text byte runs only the roll while the window is filling, and once it is
// full a drop of the oldest byte, then the roll. On a hash hit the window is
// compared against the pattern byte by byte (a read state, then a check
// state) through the two RAM read ports, and then the result is emitted.
// Reset is synchronous; it clears the pattern, the text and the modulus to
// 101. A result waits in the output register while the receiver stalls; the
// next request is still accepted, and only a further result waits until the
// register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rolling_hash_pattern_matcher_core import rhpm_pkg::*; #(
  parameter int MAX_PATTERN = MAX_PATTERN_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [HASH_W-1:0] cfg_wdata,
  rhpm_in_if.sink                item,
  rhpm_out_if.source             result
);

  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int XW    = (INDEX_BITS > OUT_IDX_W) ? INDEX_BITS : OUT_IDX_W;
  localparam logic [CNT_W:0]   MAX_C   = (CNT_W + 1)'(MAX_PATTERN);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PATTERN);
  localparam logic [PTR_W-1:0] LAST    = PTR_W'(MAX_PATTERN - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PHASH = 9'b000000010,
    S_PPOW  = 9'b000000100,
    S_OLD   = 9'b000001000,
    S_DROP  = 9'b000010000,
    S_ROLL  = 9'b000100000,
    S_CRD   = 9'b001000000,
    S_CCHK  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  function automatic logic [PTR_W-1:0] wrap_back(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] n);
    logic [CNT_W:0] d;
    d = (CNT_W + 1)'(p) + MAX_C - {1'b0, n};
    if (d >= MAX_C) begin
      d = d - MAX_C;
    end
    return d[PTR_W-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  state_t                  state;
  logic [HASH_W-1:0]       modulus;
  logic [CNT_W-1:0]        count;
  logic [HASH_W-1:0]       phash;
  logic [HASH_W-1:0]       lp;
  logic [HASH_W-1:0]       whash;
  logic [INDEX_BITS-1:0]   pos;
  logic [PTR_W-1:0]        head;
  logic [CNT_W-1:0]        fill;
  logic [BYTE_W-1:0]       byte_q;
  logic [CNT_W-1:0]        j;
  logic [PTR_W-1:0]        rp;
  logic                    match_flag;
  logic                    out_valid;
  logic                    out_match;
  logic [OUT_IDX_W-1:0]    out_idx;

  logic                    accept;
  logic [HASH_W-1:0]       m_eff;
  mod_req_t                mreq;
  mod_stat_t               mstat;
  logic [HASH_W-1:0]       mres;
  logic                    pat_we;
  logic [BYTE_W-1:0]       pat_rdata;
  logic                    ring_we;
  logic [PTR_W-1:0]        ring_raddr;
  logic [BYTE_W-1:0]       ring_rdata;
  logic [CNT_W-1:0]        fill_next;
  logic [PTR_W-1:0]        head_next;
  logic [INDEX_BITS-1:0]   idx_start;
  logic [XW-1:0]           idx_wide;

  assign accept = item.valid && item.ready;
  assign m_eff  = (modulus == '0) ? HASH_W'(1) : modulus;

  assign fill_next = (fill < count) ? fill + 1'b1 : fill;
  assign head_next = next_ptr(head);
  assign idx_start = pos + INDEX_BITS'(1) - INDEX_BITS'(count);
  assign idx_wide  = XW'(idx_start);

  assign pat_we  = (state == S_IDLE) && accept && !cfg_we &&
                   (item.command == CMD_PATTERN) && (count < MAX_CNT);
  assign ring_we = (state == S_ROLL) && mstat.done && !cfg_we;
  assign ring_raddr = (state == S_IDLE) ? wrap_back(head, count) : rp;

  always_comb begin
    mreq       = '0;
    mreq.abort = cfg_we;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.command == CMD_PATTERN && count < MAX_CNT) begin
            mreq.start = 1'b1;
            mreq.init  = phash;
            mreq.data  = item.data_byte;
          end else if (item.command == CMD_TEXT && count != '0 && fill < count) begin
            mreq.start = 1'b1;
            mreq.init  = whash;
            mreq.data  = item.data_byte;
          end
        end
      end
      S_PHASH: begin
        if (mstat.done) begin
          mreq.start = 1'b1;
          mreq.init  = (count == '0) ? '0 : lp;
          mreq.data  = (count == '0) ? BYTE_W'(1) : '0;
        end
      end
      S_OLD: begin
        mreq.start = 1'b1;
        mreq.mul   = 1'b1;
        mreq.data  = ring_rdata;
        mreq.mcand = lp;
      end
      S_DROP: begin
        if (mstat.done) begin
          mreq.start = 1'b1;
          mreq.init  = (whash >= mres) ? whash - mres : whash + m_eff - mres;
          mreq.data  = byte_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      modulus   <= MODULUS_RESET;
      count     <= '0;
      phash     <= '0;
      lp        <= HASH_W'(1);
      whash     <= '0;
      pos       <= '0;
      head      <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (result.ready && (cfg_we || state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        modulus <= cfg_wdata;
        state   <= S_IDLE;
        count   <= '0;
        phash   <= '0;
        lp      <= HASH_W'(1);
        whash   <= '0;
        pos     <= '0;
        head    <= '0;
        fill    <= '0;
      end else begin
        case (state)
          S_IDLE: begin
            if (accept) begin
              byte_q <= item.data_byte;
              case (item.command)
                CMD_TEXT: begin
                  if (count != '0) begin
                    state <= (fill < count) ? S_ROLL : S_OLD;
                  end
                end
                CMD_PATTERN: begin
                  whash <= '0;
                  pos   <= '0;
                  head  <= '0;
                  fill  <= '0;
                  if (count < MAX_CNT) begin
                    state <= S_PHASH;
                  end
                end
                CMD_CLEAR: begin
                  count <= '0;
                  phash <= '0;
                  lp    <= HASH_W'(1);
                  whash <= '0;
                  pos   <= '0;
                  head  <= '0;
                  fill  <= '0;
                end
                default: begin
                end
              endcase
            end
          end
          S_PHASH: begin
            if (mstat.done) begin
              phash <= mres;
              state <= S_PPOW;
            end
          end
          S_PPOW: begin
            if (mstat.done) begin
              lp    <= mres;
              count <= count + 1'b1;
              state <= S_IDLE;
            end
          end
          S_OLD: begin
            state <= S_DROP;
          end
          S_DROP: begin
            if (mstat.done) begin
              state <= S_ROLL;
            end
          end
          S_ROLL: begin
            if (mstat.done) begin
              whash <= mres;
              head  <= head_next;
              fill  <= fill_next;
              if (fill_next == count && mres == phash) begin
                j     <= '0;
                rp    <= wrap_back(head_next, count);
                state <= S_CRD;
              end else begin
                pos   <= pos + 1'b1;
                state <= S_IDLE;
              end
            end
          end
          S_CRD: begin
            state <= S_CCHK;
          end
          S_CCHK: begin
            if (ring_rdata != pat_rdata) begin
              match_flag <= 1'b0;
              state      <= S_EMIT;
            end else if ((j + 1'b1) == count) begin
              match_flag <= 1'b1;
              state      <= S_EMIT;
            end else begin
              j     <= j + 1'b1;
              rp    <= next_ptr(rp);
              state <= S_CRD;
            end
          end
          S_EMIT: begin
            if (!out_valid || result.ready) begin
              out_valid <= 1'b1;
              out_match <= match_flag;
              out_idx   <= idx_wide[OUT_IDX_W-1:0];
              pos       <= pos + 1'b1;
              state     <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  rhpm_mod_unit u_mod (
    .clk  (clk),
    .rst  (rst),
    .req  (mreq),
    .m    (m_eff),
    .stat (mstat),
    .res  (mres)
  );

  rhpm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_pattern_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (count[PTR_W-1:0]),
    .wdata (item.data_byte),
    .raddr (j[PTR_W-1:0]),
    .rdata (pat_rdata)
  );

  rhpm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_PATTERN)
  ) u_window_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head),
    .wdata (byte_q),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = out_valid;
  assign result.true_match  = out_match;
  assign result.start_index = out_idx;

  `ASSERT_ALWAYS(a_fill_le_count, clk, rst, fill <= count)
  `ASSERT_ALWAYS(a_head_range, clk, rst, head <= LAST)
  `ASSERT_IMPLIES(a_emit_full, clk, rst, state == S_EMIT, fill == count && count != '0)
  `ASSERT_IMPLIES(a_busy_state, clk, rst, mstat.busy, state == S_PHASH || state == S_PPOW || state == S_DROP || state == S_ROLL)

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rhpm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam int MAX_PAT = MAX_PATTERN_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TARGET_ITEMS = 750;
  localparam int SWEEP_LEN = 10;

  typedef struct packed {
    logic                 true_match;
    logic [OUT_IDX_W-1:0] start_index;
  } match_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data;
  } request_t;

  localparam logic [HASH_W-1:0] MODULUS_SWEEP [SWEEP_LEN] = '{
    16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd101, 16'd251, 16'd256, 16'd257, 16'd65521, 16'd3
  };

  // Runs at the reset modulus of 101; 0x66 and 0xCA collide with 0x01 and 0x00.
  localparam request_t OPENING [21] = '{
    '{CMD_IGNORED, 8'hAA}, '{CMD_TEXT, 8'h55},
    '{CMD_PATTERN, 8'h00}, '{CMD_PATTERN, 8'hFF},
    '{CMD_TEXT, 8'h00}, '{CMD_TEXT, 8'hFF}, '{CMD_TEXT, 8'h00}, '{CMD_TEXT, 8'hFF},
    '{CMD_PATTERN, 8'h80},
    '{CMD_TEXT, 8'h00}, '{CMD_TEXT, 8'hFF}, '{CMD_TEXT, 8'h80},
    '{CMD_CLEAR, 8'h3C},
    '{CMD_PATTERN, 8'h01},
    '{CMD_TEXT, 8'h66}, '{CMD_TEXT, 8'h01}, '{CMD_TEXT, 8'hCA},
    '{CMD_CLEAR, 8'hC3},
    '{CMD_TEXT, 8'h01},
    '{CMD_PATTERN, 8'h7F}, '{CMD_TEXT, 8'h7F}
  };

  class match_scoreboard;
    int unsigned modulus;
    logic [BYTE_W-1:0] pattern_bytes [MAX_PAT];
    logic [BYTE_W-1:0] window_bytes [MAX_PAT];
    int unsigned pattern_len, pattern_hash, lead_weight;
    int unsigned window_hash, window_fill, ring_head;
    logic [OUT_IDX_W-1:0] text_pos;
    match_t expected_q [$];
    int mismatches;

    function new();
      modulus = MODULUS_RESET;
      mismatches = 0;
      clear_all();
    endfunction

    function void clear_text();
      window_hash = 0;
      window_fill = 0;
      ring_head = 0;
      text_pos = '0;
    endfunction

    function void clear_all();
      pattern_len = 0;
      pattern_hash = 0;
      lead_weight = 1;
      clear_text();
    endfunction

    function void set_modulus(logic [HASH_W-1:0] value);
      modulus = value;
      clear_all();
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
      int unsigned m, drop, oldest;
      bit same;
      match_t hit;
      m = (modulus == 0) ? 1 : modulus;
      case (cmd)
        CMD_PATTERN: begin
          clear_text();
          if (pattern_len < MAX_PAT) begin
            pattern_bytes[pattern_len] = b;
            pattern_hash = (pattern_hash * 256 + b) % m;
            lead_weight = (pattern_len == 0) ? 1 % m : (lead_weight * 256) % m;
            pattern_len++;
          end
        end
        CMD_CLEAR: begin
          clear_all();
        end
        CMD_TEXT: begin
          if (pattern_len != 0) begin
            if (window_fill < pattern_len) begin
              window_fill++;
            end else begin
              oldest = window_bytes[(ring_head + MAX_PAT - pattern_len) % MAX_PAT];
              drop = (oldest * lead_weight) % m;
              window_hash = (window_hash + m - drop) % m;
            end
            window_hash = (window_hash * 256 + b) % m;
            window_bytes[ring_head] = b;
            ring_head = (ring_head + 1) % MAX_PAT;
            if (window_fill == pattern_len && window_hash == pattern_hash) begin
              same = 1'b1;
              for (int j = 0; j < pattern_len; j++) begin
                if (window_bytes[(ring_head + MAX_PAT - pattern_len + j) % MAX_PAT]
                    != pattern_bytes[j]) same = 1'b0;
              end
              hit.true_match = same;
              hit.start_index = text_pos + 1 - pattern_len;
              expected_q.push_back(hit);
            end
            text_pos++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(match_t got);
      match_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: true_match=%0b start_index=%0d",
                   got.true_match, got.start_index);
        return;
      end
      want = expected_q.pop_front();
      if (got.true_match !== want.true_match || got.start_index !== want.start_index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected true_match=%0b start_index=%0d, got %0b %0d",
                   want.true_match, want.start_index, got.true_match, got.start_index);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [HASH_W-1:0] cfg_wdata;
  rhpm_in_if req_ch ();
  rhpm_out_if res_ch ();

  match_scoreboard sb;
  int unsigned cycles = 0;
  int items_sent;
  bit calm_in, calm_out;

  rolling_hash_pattern_matcher_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .item(req_ch),
    .result(res_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte(bit narrow, logic [BYTE_W-1:0] base);
    return narrow ? BYTE_W'(base + $urandom_range(0, 2)) : BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.command <= cmd;
    req_ch.data_byte <= b;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(cmd, b);
    if (cmd != CMD_IGNORED) items_sent++;
  endtask

  task automatic append_pattern(ref logic [BYTE_W-1:0] pat [$], input logic [BYTE_W-1:0] b);
    send_request(CMD_PATTERN, b);
    if (pat.size() < MAX_PAT) pat.push_back(b);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_modulus(logic [HASH_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_modulus(value);
  endtask

  task automatic run_phase(int unsigned phase);
    logic [BYTE_W-1:0] pat [$];
    logic [BYTE_W-1:0] base;
    bit narrow;
    int unsigned plen, tlen, sent_text, pick, runlen, flip;
    settle();
    write_modulus(phase < SWEEP_LEN ? MODULUS_SWEEP[phase] :
                  HASH_W'($urandom_range(2, 65535)));
    calm_in = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    narrow = $urandom_range(0, 1);
    base = $urandom_range(0, 253);
    pick = $urandom_range(0, 9);
    if (phase == 3) plen = 68;
    else if (phase == 7) plen = 64;
    else if (pick < 7) plen = $urandom_range(1, 6);
    else if (pick < 9) plen = $urandom_range(7, 16);
    else plen = $urandom_range(17, 40);
    repeat (plen) append_pattern(pat, pick_byte(narrow, base));
    tlen = (plen > 20) ? $urandom_range(70, 140) : $urandom_range(20, 60);
    sent_text = 0;
    while (sent_text < tlen) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        foreach (pat[i]) send_request(CMD_TEXT, pat[i]);
        sent_text += pat.size();
      end else if (pick < 6) begin
        flip = $urandom_range(0, pat.size() - 1);
        foreach (pat[i])
          send_request(CMD_TEXT, (i == flip) ? pat[i] ^ BYTE_W'($urandom_range(1, 255)) : pat[i]);
        sent_text += pat.size();
      end else if (pick < 9) begin
        runlen = $urandom_range(1, 6);
        repeat (runlen) send_request(CMD_TEXT, pick_byte(narrow, base));
        sent_text += runlen;
      end else begin
        case ($urandom_range(0, 2))
          0: send_request(CMD_IGNORED, BYTE_W'($urandom_range(0, 255)));
          1: begin
            send_request(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)));
            pat.delete();
            repeat ($urandom_range(1, 4)) append_pattern(pat, pick_byte(narrow, base));
          end
          default: append_pattern(pat, pick_byte(narrow, base));
        endcase
        sent_text++;
      end
    end
  endtask

  initial begin
    match_t got;
    int unsigned stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      got.true_match = res_ch.true_match;
      got.start_index = res_ch.start_index;
      sb.check_result(got);
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TEXT;
    req_ch.data_byte = '0;
    res_ch.ready = 1'b0;
    calm_in = 1'b0;
    calm_out = 1'b0;
    items_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (OPENING[i]) send_request(OPENING[i].cmd, OPENING[i].data);
    for (int unsigned phase = 0; items_sent < TARGET_ITEMS || phase < SWEEP_LEN; phase++)
      run_phase(phase);
    settle();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
